// ===== rtl/core/servo_scan_sweep_with_range_table_defines.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef SERVO_SCAN_SWEEP_WITH_RANGE_TABLE_DEFINES_SVH
`define SERVO_SCAN_SWEEP_WITH_RANGE_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSR_ASSERT(lbl, prop, msg)
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ssr_pkg.sv =====
package ssr_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // Input item codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SWEEP_MIN  = 3'd0;
  localparam logic [2:0] REG_SWEEP_MAX  = 3'd1;
  localparam logic [2:0] REG_STEP_ANGLE = 3'd2;
  localparam logic [2:0] REG_PERIOD     = 3'd3;
  localparam logic [2:0] REG_SETTLE     = 3'd4;
  localparam logic [2:0] REG_PULSE_MIN  = 3'd5;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd6;

  localparam logic [7:0]  RST_SWEEP_MIN  = 8'd20;
  localparam logic [7:0]  RST_SWEEP_MAX  = 8'd160;
  localparam logic [7:0]  RST_STEP_ANGLE = 8'd10;
  localparam logic [9:0]  RST_PERIOD     = 10'd200;
  localparam logic [15:0] RST_SETTLE     = 16'd50;
  localparam logic [11:0] RST_PULSE_MIN  = 12'd500;
  localparam logic [11:0] RST_PULSE_MAX  = 12'd2500;

  localparam logic signed [14:0] NO_READING = 15'sd9999;
  localparam logic signed [14:0] NONE_DIST  = -15'sd1;
  localparam logic [7:0]  PARK_ANGLE  = 8'd90;
  localparam logic [12:0] PULSE_BASE  = 13'd500;
  // angle * 2000 / 180 == (angle * PULSE_RECIP) >> PULSE_SHIFT for angle < 256.
  localparam logic [21:0] PULSE_RECIP = 22'd2912800;
  localparam int          PULSE_SHIFT = 18;

endpackage

// ===== rtl/core/servo_scan_sweep_with_range_table.sv =====
// Servo sweep range scanner. Each input transaction is a one millisecond tick, a start,
// a stop or a query, and each produces exactly one result transaction. Ticks step the
// servo between the sweep limits and, once the settle time has passed, record the
// distance reading in a per-angle table held in a RAM with separate read and write
// ports. A tick that only counts time goes straight to the result, while a step, a
// start or a stop first computes the pulse width with one multiply and a clamp. A
// sample walks the table one entry per cycle looking for its angle. A query walks
// the whole table, then runs a bit-serial divider for the cone mean when the cone
// holds a positive reading. The table walk and the divider set the rate; the block
// takes one transaction at a time but accepts the next one while the previous result
// still waits on the output, and a result that cannot leave holds the block in its
// last state. The table needs no clearing after reset: only entries below the fill
// count are read.
`include "servo_scan_sweep_with_range_table_defines.svh"

module servo_scan_sweep_with_range_table #(
  parameter int TABLE_DEPTH = ssr_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [14:0] distance_reading,
  input  logic [7:0]         query_angle,
  input  logic [7:0]         query_tolerance,
  input  logic [8:0]         cone_width,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               servo_valid,
  output logic [7:0]         servo_angle,
  output logic [11:0]        servo_pulse_us,
  output logic               point_valid,
  output logic [7:0]         point_angle,
  output logic signed [14:0] point_distance,
  output logic [31:0]        point_time,
  output logic signed [14:0] closest_distance,
  output logic [7:0]         nearest_angle,
  output logic signed [14:0] angle_distance,
  output logic signed [14:0] cone_average,
  output logic               table_full
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  // A sum of up to TABLE_DEPTH readings of at most 14 bits each.
  localparam int SW  = 14 + CW;
  localparam int DIW = $clog2(SW + 1);
  localparam int PW  = 30;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_WALK     = 7'b0000100,
    S_DIV      = 7'b0001000,
    S_PULSE    = 7'b0010000,
    S_CLAMP    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]  sweep_min, sweep_max, step_ang;
  logic [9:0]  period;
  logic [15:0] settle;
  logic [11:0] pulse_min, pulse_max;

  // Scanner state.
  logic        running, settling, sweep_down;
  logic [7:0]  cur_angle;
  logic [31:0] ms_count;
  // Settle start and last step are always set together, so one mark serves both.
  logic [31:0] mark_time;
  logic [CW-1:0] entry_count;

  // Latched input transaction.
  logic [1:0]         mode_r;
  logic signed [14:0] dist_r;
  logic [7:0]         qa_r, tol_r;
  logic [8:0]         cone_r;

  // Result being built.
  logic               w_servo_valid, w_point_valid, w_full;
  logic [7:0]         w_servo_angle, w_point_angle, w_cl_angle;
  logic [11:0]        w_pulse;
  logic signed [14:0] w_point_dist, w_closest, w_at, w_cone;
  logic [31:0]        w_point_time;
  logic               have_at;

  // Table walk and divider.
  logic [CW-1:0]  idx, pidx;
  logic           rd_pend;
  logic [SW-1:0]  sum;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  rem;
  logic [DIW-1:0] div_i;
  logic [PW-1:0]  prod;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [22:0]   ram_wdata, ram_rdata;

  ssr_ram #(
    .WIDTH (23),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry just read.
  logic [7:0]         ent_ang;
  logic signed [14:0] ent_dist;
  logic               is_sample, is_query;
  logic               match, issue, walk_end;
  logic signed [9:0]  adiff;
  logic signed [10:0] cone_lo, cone_hi, ent_s;
  logic               ent_pos, in_cone, near;
  logic [31:0]        elapsed;
  logic [31:0]        need;
  logic               due;
  logic signed [9:0]  step_sum;
  logic [7:0]         step_angle_next;
  logic               step_down_next;
  logic [CW:0]        trial;
  logic               qbit;
  logic [12:0]        us_raw, us_lo, us_clamped;

  always_comb begin
    ent_ang   = ram_rdata[22:15];
    ent_dist  = $signed(ram_rdata[14:0]);
    is_query  = (mode_r == ssr_pkg::MODE_QUERY);
    is_sample = !is_query;
    match     = rd_pend && is_sample && (ent_ang == cur_angle);
    issue     = (state == S_WALK) && (idx < entry_count) && !match;
    walk_end  = (state == S_WALK) && !rd_pend && (idx >= entry_count);
    ram_raddr = idx[AW-1:0];

    // A sample overwrites the entry holding its angle, or appends if there is room.
    ram_we    = 1'b0;
    ram_waddr = pidx[AW-1:0];
    ram_wdata = {cur_angle, dist_r};
    if (state == S_WALK && is_sample) begin
      if (match) begin
        ram_we = 1'b1;
      end else if (walk_end && entry_count < CW'(TABLE_DEPTH)) begin
        ram_we    = 1'b1;
        ram_waddr = entry_count[AW-1:0];
      end
    end

    // Query tests on the entry just read.
    adiff   = $signed({2'b00, ent_ang}) - $signed({2'b00, qa_r});
    if (adiff < 0) begin
      adiff = -adiff;
    end
    near    = (adiff <= $signed({2'b00, tol_r}));
    ent_pos = (ent_dist > 0);
    ent_s   = $signed({3'b000, ent_ang});
    cone_lo = $signed({3'b000, qa_r}) - $signed({3'b000, cone_r[8:1]});
    cone_hi = $signed({3'b000, qa_r}) + $signed({3'b000, cone_r[8:1]});
    in_cone = (ent_s >= cone_lo) && (ent_s <= cone_hi);

    // One shared elapsed-time compare for both the settle wait and the step period.
    elapsed = ms_count - mark_time;
    need    = settling ? {16'd0, settle} : {22'd0, period};
    due     = (elapsed >= need);

    // Next sweep position, clamped at the limits with a turn of direction.
    step_sum = sweep_down ? ($signed({2'b00, cur_angle}) - $signed({2'b00, step_ang}))
                          : ($signed({2'b00, cur_angle}) + $signed({2'b00, step_ang}));
    step_down_next = sweep_down;
    if (step_sum > $signed({2'b00, sweep_max})) begin
      step_angle_next = sweep_max;
      step_down_next  = 1'b1;
    end else if (step_sum < $signed({2'b00, sweep_min})) begin
      step_angle_next = sweep_min;
      step_down_next  = 1'b0;
    end else begin
      step_angle_next = step_sum[7:0];
    end

    // Restoring divider, one quotient bit per cycle.
    trial = {rem, sum[SW-1]};
    qbit  = (trial >= {1'b0, cnt});

    // Pulse width with the upper clamp applied last.
    us_raw     = ssr_pkg::PULSE_BASE + {1'b0, prod[PW-1:ssr_pkg::PULSE_SHIFT]};
    us_lo      = (us_raw < {1'b0, pulse_min}) ? {1'b0, pulse_min} : us_raw;
    us_clamped = (us_lo > {1'b0, pulse_max}) ? {1'b0, pulse_max} : us_lo;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_min <= ssr_pkg::RST_SWEEP_MIN;
      sweep_max <= ssr_pkg::RST_SWEEP_MAX;
      step_ang  <= ssr_pkg::RST_STEP_ANGLE;
      period    <= ssr_pkg::RST_PERIOD;
      settle    <= ssr_pkg::RST_SETTLE;
      pulse_min <= ssr_pkg::RST_PULSE_MIN;
      pulse_max <= ssr_pkg::RST_PULSE_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssr_pkg::REG_SWEEP_MIN:  sweep_min <= cfg_data[7:0];
        ssr_pkg::REG_SWEEP_MAX:  sweep_max <= cfg_data[7:0];
        ssr_pkg::REG_STEP_ANGLE: step_ang  <= cfg_data[7:0];
        ssr_pkg::REG_PERIOD:     period    <= cfg_data[9:0];
        ssr_pkg::REG_SETTLE:     settle    <= cfg_data;
        ssr_pkg::REG_PULSE_MIN:  pulse_min <= cfg_data[11:0];
        ssr_pkg::REG_PULSE_MAX:  pulse_max <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      running     <= 1'b0;
      settling    <= 1'b0;
      sweep_down  <= 1'b0;
      cur_angle   <= ssr_pkg::PARK_ANGLE;
      ms_count    <= '0;
      mark_time   <= '0;
      entry_count <= '0;
      rd_pend     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r        <= mode;
            dist_r        <= distance_reading;
            qa_r          <= query_angle;
            tol_r         <= query_tolerance;
            cone_r        <= cone_width;
            w_servo_valid <= 1'b0;
            w_servo_angle <= '0;
            w_pulse       <= '0;
            w_point_valid <= 1'b0;
            w_point_angle <= '0;
            w_point_dist  <= '0;
            w_point_time  <= '0;
            w_closest     <= '0;
            w_cl_angle    <= '0;
            w_at          <= '0;
            w_cone        <= '0;
            w_full        <= 1'b0;
            if (mode == ssr_pkg::MODE_TICK) begin
              ms_count <= ms_count + 32'd1;
            end
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          case (mode_r)
            ssr_pkg::MODE_TICK: begin
              if (running && settling && due) begin
                settling <= 1'b0;
                state    <= S_WALK;
              end else if (running && !settling && due) begin
                cur_angle     <= step_angle_next;
                sweep_down    <= step_down_next;
                w_servo_angle <= step_angle_next;
                mark_time     <= ms_count;
                settling      <= 1'b1;
                state         <= S_PULSE;
              end else begin
                state <= S_DONE;
              end
            end
            ssr_pkg::MODE_START: begin
              if (!running) begin
                running       <= 1'b1;
                cur_angle     <= sweep_min;
                w_servo_angle <= sweep_min;
                sweep_down    <= 1'b0;
                entry_count   <= '0;
                mark_time     <= ms_count;
                settling      <= 1'b1;
                state         <= S_PULSE;
              end else begin
                state <= S_DONE;
              end
            end
            ssr_pkg::MODE_STOP: begin
              if (running) begin
                running       <= 1'b0;
                cur_angle     <= ssr_pkg::PARK_ANGLE;
                w_servo_angle <= ssr_pkg::PARK_ANGLE;
                state         <= S_PULSE;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              w_closest  <= ssr_pkg::NO_READING;
              w_cl_angle <= ssr_pkg::PARK_ANGLE;
              w_at       <= ssr_pkg::NONE_DIST;
              have_at    <= 1'b0;
              sum        <= '0;
              cnt        <= '0;
              state      <= S_WALK;
            end
          endcase
        end
        S_WALK: begin
          rd_pend <= issue;
          if (issue) begin
            idx  <= idx + CW'(1);
            pidx <= idx;
          end
          if (rd_pend && is_query) begin
            if (ent_pos && ent_dist < w_closest) begin
              w_closest  <= ent_dist;
              w_cl_angle <= ent_ang;
            end
            if (!have_at && near) begin
              w_at    <= ent_dist;
              have_at <= 1'b1;
            end
            if (ent_pos && in_cone) begin
              sum <= sum + SW'(ent_dist[13:0]);
              cnt <= cnt + CW'(1);
            end
          end
          if (is_sample && (match || walk_end)) begin
            w_point_valid <= 1'b1;
            w_point_angle <= cur_angle;
            w_point_dist  <= dist_r;
            w_point_time  <= ms_count;
            if (!match) begin
              if (entry_count < CW'(TABLE_DEPTH)) begin
                entry_count <= entry_count + CW'(1);
              end else begin
                w_full <= 1'b1;
              end
            end
            state <= S_DONE;
          end else if (is_query && walk_end) begin
            if (w_closest == ssr_pkg::NO_READING) begin
              w_closest <= ssr_pkg::NONE_DIST;
            end
            if (cnt != '0) begin
              rem   <= '0;
              div_i <= DIW'(SW);
              state <= S_DIV;
            end else begin
              w_cone <= ssr_pkg::NONE_DIST;
              state  <= S_DONE;
            end
          end
        end
        S_DIV: begin
          // The quotient shifts in from the bottom as the dividend leaves the top.
          rem   <= qbit ? CW'(trial - {1'b0, cnt}) : trial[CW-1:0];
          sum   <= {sum[SW-2:0], qbit};
          div_i <= div_i - DIW'(1);
          if (div_i == DIW'(1)) begin
            state <= S_DONE;
          end
        end
        S_PULSE: begin
          prod  <= {22'd0, w_servo_angle} * {8'd0, ssr_pkg::PULSE_RECIP};
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          w_servo_valid <= 1'b1;
          w_pulse       <= us_clamped[11:0];
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            servo_valid      <= w_servo_valid;
            servo_angle      <= w_servo_angle;
            servo_pulse_us   <= w_pulse;
            point_valid      <= w_point_valid;
            point_angle      <= w_point_angle;
            point_distance   <= w_point_dist;
            point_time       <= w_point_time;
            closest_distance <= w_closest;
            nearest_angle    <= w_cl_angle;
            angle_distance   <= w_at;
            table_full       <= w_full;
            if (is_query && cnt != '0) begin
              cone_average <= $signed(sum[14:0]);
            end else begin
              cone_average <= w_cone;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count never passes the table size.
  `SSR_ASSERT(a_count_bound, entry_count <= CW'(TABLE_DEPTH), "table fill count overflow")
  // An accepted transaction is always dispatched on the next cycle.
  `SSR_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state == S_DISPATCH, "no dispatch")
  // A stop while running parks the servo.
  `SSR_ASSERT_NEXT(a_stop_park, state == S_DISPATCH && mode_r == ssr_pkg::MODE_STOP && running, !running && cur_angle == ssr_pkg::PARK_ANGLE, "stop did not park")
  // The divider never runs with a zero divisor.
  `SSR_ASSERT(a_div_nonzero, state != S_DIV || cnt != '0, "divide by zero count")

endmodule

// ===== rtl/core/ssr_ram.sv =====
module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
